@@ rtl/core/shce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package shce_pkg;

    localparam int ORDER_BITS = 2;
    localparam int LEVEL_BITS = 16;
    // extra integer bits carried by the Horner accumulator above the coefficient width
    localparam int H_GUARD    = 4;

    // a stage register takes new data when it is empty or its content moves on
    function automatic logic stage_load(input logic valid, input logic next_load);
        return !valid || next_load;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/shce_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module shce_step #(
    parameter int H_W    = 20,
    parameter int X_W    = 13,
    parameter int SIDE_W = 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [H_W-1:0]   i_h,
    input  wire logic signed [H_W-1:0]   i_c,
    input  wire logic [X_W-1:0]          i_x,
    input  wire logic [SIDE_W-1:0]       i_side,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [H_W-1:0]        o_h,
    output logic [SIDE_W-1:0]            o_side
);
    import shce_pkg::*;

    localparam int P_W = H_W + X_W + 1;
    localparam int S_W = P_W + 1;
    localparam logic signed [S_W-1:0] LIM_POS = {{(S_W-H_W+1){1'b0}}, {(H_W-1){1'b1}}};
    localparam logic signed [S_W-1:0] LIM_NEG = -LIM_POS;

    logic                    r_va;
    logic                    r_vb;
    logic signed [P_W-1:0]   r_prod;
    logic signed [H_W-1:0]   r_ca;
    logic [SIDE_W-1:0]       r_side_a;
    logic signed [H_W-1:0]   r_h;
    logic [SIDE_W-1:0]       r_side_b;

    logic signed [P_W-1:0]   n_prod;
    logic signed [S_W-1:0]   sum;
    logic signed [H_W-1:0]   n_h;
    logic                    en_a;
    logic                    en_b;

    assign en_b    = stage_load(r_vb, i_ready);
    assign en_a    = stage_load(r_va, en_b);
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_h     = r_h;
    assign o_side  = r_side_b;

    always_comb begin
        n_prod = P_W'(i_h) * P_W'($signed({1'b0, i_x}));
        sum    = S_W'(r_prod) + S_W'(r_ca);
        // clip far outside the useful range; sign and size still force the same rail
        if (sum > LIM_POS) begin
            n_h = H_W'(LIM_POS);
        end else if (sum < LIM_NEG) begin
            n_h = H_W'(LIM_NEG);
        end else begin
            n_h = H_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_prod   <= n_prod;
            r_ca     <= i_c;
            r_side_a <= i_side;
        end
        if (en_b) begin
            r_h      <= n_h;
            r_side_b <= r_side_a;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/scaled_cubic_horner_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Cubic segment evaluator: level = round(clamp(y, 0, 1) * (2^COEF_BITS - 1)) with
// y = base/B + (2*c1*x + c2*x^2 + 0.5*c3*x^3) / S, terms above the segment order
// dropped. Fully pipelined: one transaction accepted per cycle while the output
// side keeps up. The pipeline is three registered multiplies by the position (two
// Horner steps plus the final product), each followed by a saturating add or the
// rounding/clamp stage. Back-pressure only fills empty stages; nothing is dropped
// or repeated.
module scaled_cubic_horner_eval #(
    parameter int COEF_BITS = 16,
    parameter int MAX_ORDER = 3,
    parameter int POS_BITS  = 13
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [shce_pkg::ORDER_BITS-1:0]        i_order,
    input  wire logic [COEF_BITS-1:0]                   i_base_coef,
    input  wire logic signed [COEF_BITS-1:0]            i_coef_linear,
    input  wire logic signed [COEF_BITS-1:0]            i_coef_square,
    input  wire logic signed [COEF_BITS-1:0]            i_coef_cube,
    input  wire logic [POS_BITS-1:0]                    i_x_pos,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [shce_pkg::LEVEL_BITS-1:0]             o_level
);
    import shce_pkg::*;

    localparam int H_W     = COEF_BITS + H_GUARD;
    localparam int P_W     = H_W + POS_BITS + 1;
    localparam int L_W     = COEF_BITS + 3;
    localparam int SIDE0_W = H_W + COEF_BITS + POS_BITS;
    localparam int SIDE1_W = COEF_BITS + POS_BITS;
    localparam logic [ORDER_BITS-1:0] ORD_MAX = ORDER_BITS'(MAX_ORDER);
    localparam logic signed [P_W-1:0] TWO_S   = P_W'((1 << COEF_BITS) - 2);
    localparam logic signed [P_W-1:0] S_VAL   = P_W'((1 << (COEF_BITS - 1)) - 1);
    localparam logic signed [L_W-1:0] B_L     = L_W'((1 << COEF_BITS) - 1);
    localparam logic [COEF_BITS-1:0]  B_MAX   = '1;

    logic [ORDER_BITS-1:0]   ord_eff;
    logic signed [H_W-1:0]   h_init;
    logic signed [H_W-1:0]   c2x2;
    logic signed [H_W-1:0]   c1x4;
    logic [SIDE0_W-1:0]      side0_in;

    logic                    s0_valid;
    logic                    s0_ready;
    logic signed [H_W-1:0]   s0_h;
    logic [SIDE0_W-1:0]      s0_side;
    logic signed [H_W-1:0]   s0_c1x4;
    logic [COEF_BITS-1:0]    s0_base;
    logic [POS_BITS-1:0]     s0_x;

    logic                    s1_valid;
    logic signed [H_W-1:0]   s1_h;
    logic [SIDE1_W-1:0]      s1_side;
    logic [COEF_BITS-1:0]    s1_base;
    logic [POS_BITS-1:0]     s1_x;

    logic                    r_v5;
    logic signed [P_W-1:0]   r_p;
    logic [COEF_BITS-1:0]    r_base5;
    logic                    r_v6;
    logic [LEVEL_BITS-1:0]   r_level;

    logic signed [P_W-1:0]   n_p;
    logic [LEVEL_BITS-1:0]   n_level;
    logic signed [L_W-1:0]   q;
    logic signed [L_W-1:0]   t;
    logic [COEF_BITS-1:0]    lvl;
    logic                    en5;
    logic                    en6;

    // zero the coefficients above the segment order; Horner then runs all steps
    always_comb begin
        ord_eff  = (i_order > ORD_MAX) ? ORD_MAX : i_order;
        h_init   = (ord_eff >= ORDER_BITS'(3)) ? H_W'(i_coef_cube) : '0;
        c2x2     = (ord_eff >= ORDER_BITS'(2)) ? (H_W'(i_coef_square) <<< 1) : '0;
        c1x4     = (ord_eff >= ORDER_BITS'(1)) ? (H_W'(i_coef_linear) <<< 2) : '0;
        side0_in = {c1x4, i_base_coef, i_x_pos};
    end

    shce_step #(
        .H_W    (H_W),
        .X_W    (POS_BITS),
        .SIDE_W (SIDE0_W)
    ) u_step0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_h     (h_init),
        .i_c     (c2x2),
        .i_x     (i_x_pos),
        .i_side  (side0_in),
        .o_valid (s0_valid),
        .i_ready (s0_ready),
        .o_h     (s0_h),
        .o_side  (s0_side)
    );

    assign {s0_c1x4, s0_base, s0_x} = s0_side;

    shce_step #(
        .H_W    (H_W),
        .X_W    (POS_BITS),
        .SIDE_W (SIDE1_W)
    ) u_step1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s0_valid),
        .o_ready (s0_ready),
        .i_h     (s0_h),
        .i_c     (s0_c1x4),
        .i_x     (s0_x),
        .i_side  ({s0_base, s0_x}),
        .o_valid (s1_valid),
        .i_ready (en5),
        .o_h     (s1_h),
        .o_side  (s1_side)
    );

    assign {s1_base, s1_x} = s1_side;

    assign en6     = stage_load(r_v6, i_ready);
    assign en5     = stage_load(r_v5, en6);
    assign o_valid = r_v6;
    assign o_level = r_level;

    assign n_p = P_W'(s1_h) * P_W'($signed({1'b0, s1_x}));

    // level = base + P + round correction, since B = 2S + 1
    always_comb begin
        if (r_p < -S_VAL) begin
            q = -L_W'(1);
        end else if (r_p >= S_VAL) begin
            q = L_W'(1);
        end else begin
            q = '0;
        end
        t = $signed(L_W'(r_base5)) + L_W'(r_p) + q;
        if (r_p >= TWO_S) begin
            lvl = B_MAX;
        end else if (r_p <= -TWO_S) begin
            lvl = '0;
        end else if (t < 0) begin
            lvl = '0;
        end else if (t > B_L) begin
            lvl = B_MAX;
        end else begin
            lvl = COEF_BITS'(t);
        end
        n_level = LEVEL_BITS'(lvl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en5) begin
                r_v5 <= s1_valid;
            end
            if (en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_p     <= n_p;
            r_base5 <= s1_base;
        end
        if (en6) begin
            r_level <= n_level;
        end
    end

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output stage empty");

    a_high_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && en6 && (r_p >= TWO_S)) |=> (o_valid && (o_level == LEVEL_BITS'(B_MAX))))
        else $error("large positive polynomial did not reach full level");

    a_low_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && en6 && (r_p <= -TWO_S)) |=> (o_valid && (o_level == '0)))
        else $error("large negative polynomial did not give zero level");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !en6) |=> (r_v5 && $stable(r_p)))
        else $error("product stage lost data under stall");
`endif

endmodule

`default_nettype wire
